FILE: rtl/running_median_two_heaps_unit_macros.svh
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit_macros
// Assertion macros for the running median unit; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// label, clock, reset_n, antecedent, consequent (next cycle), message
`define RMH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
// label, clock, reset_n, condition that must always hold, message
`define RMH_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error(msg);
`else
`define RMH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`define RMH_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond, msg)
`endif
`endif

FILE: rtl/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared constants and types for the running median unit.
// ----------------------------------------------------------------------------
package rmh_pkg;
    localparam int unsigned HEAP_DEPTH_DEF   = 512;
    localparam int unsigned SAMPLE_WIDTH_DEF = 32;
    localparam int unsigned IN_W    = 32;
    localparam int unsigned MED_W   = 33;
    localparam int unsigned CNT_OUT = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOPS,     // read tops of both heaps
        ST_TOPS_W,
        ST_DECIDE,
        ST_UP_RD,    // sift-up: read parent
        ST_UP_CMP,
        ST_DN_RD,    // sift-down: read left child
        ST_DN_W1,
        ST_DN_CMP,
        ST_FIN_RD,
        ST_FIN_W,
        ST_DONE
    } rmh_state_t;

    // operation queue codes
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP
    } rmh_op_t;
endpackage

FILE: rtl/rmh_ram.sv
// ----------------------------------------------------------------------------
// rmh_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module rmh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/running_median_two_heaps_unit.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// Running median of a signed sample stream, kept in a max-heap (lower half)
// and a min-heap (upper half), each in its own single-port RAM.
// ----------------------------------------------------------------------------
//  channel | signals                                  | handshake
//  --------+------------------------------------------+---------------------
//  in      | sample                                   | start & !busy
//  out     | median_times_two, sample_count, refused  | done strobe, 1 cycle
//
// Steps: an accepted word reads and compares the tops of both heaps; a
// refused word skips that. Each queued heap operation is then dispatched:
// a push reads the parent and compares at each level climbed and ends with
// one write; a pop loads the last entry, reads and compares the children at
// each level descended and ends with one write. Last the tops are read for
// the result. Each heap has one RAM port. done strobes in the same cycle that
// busy falls, and a new word can be taken at the edge that ends that cycle.
// Reset clears the state machine and the counts; heap RAMs need no clear.
// No stall on the output: done pulses once and the word is gone.
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_unit_macros.svh"
module running_median_two_heaps_unit
    import rmh_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH   = HEAP_DEPTH_DEF,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [IN_W-1:0]    sample,
    output logic                      done,
    output logic signed [MED_W-1:0]   median_times_two,
    output logic [CNT_OUT-1:0]        sample_count,
    output logic                      refused
);
    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned SW = SAMPLE_WIDTH;

    typedef logic signed [SW-1:0] smp_t;

    // RAM ports: index 0 = lower (max), 1 = upper (min)
    logic          we   [2];
    logic [AW-1:0] addr [2];
    smp_t          wd   [2];
    logic [SW-1:0] rd   [2];

    genvar g;
    generate
        for (g = 0; g < 2; g++)
        begin : g_heap
            rmh_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_ram (
                .clk   (clk),
                .we    (we[g]),
                .addr  (addr[g]),
                .wdata (wd[g]),
                .rdata (rd[g])
            );
        end
    endgenerate

    rmh_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    smp_t          x_reg, x_next;
    smp_t          top_reg [2];
    smp_t          top_next [2];
    // pending operation list: up to three ops (heap, kind, value)
    rmh_op_t       op_reg [3];
    rmh_op_t       op_next [3];
    logic          oh_reg [3];
    logic          oh_next [3];
    smp_t          ov_reg [3];
    smp_t          ov_next [3];
    logic          h_reg, h_next;          // heap under work
    logic [CW-1:0] i_reg, i_next;          // current index
    smp_t          v_reg, v_next;          // value being sifted
    smp_t          c_reg, c_next;          // left child value
    logic [CW-1:0] n_reg, n_next;          // size for sift-down
    logic          ref_reg, ref_next;
    logic          done_next;

    // ordering: "a ahead of b" in heap h (0 max, 1 min)
    function automatic logic ahead(input logic h, input smp_t a, input smp_t b);
        ahead = h ? (a < b) : (a > b);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            op_reg[0]  <= OP_NONE;
            op_reg[1]  <= OP_NONE;
            op_reg[2]  <= OP_NONE;
            done       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        top_reg <= top_next;
        oh_reg  <= oh_next;
        ov_reg  <= ov_next;
        h_reg   <= h_next;
        i_reg   <= i_next;
        v_reg   <= v_next;
        c_reg   <= c_next;
        n_reg   <= n_next;
        ref_reg <= ref_next;
    end

    logic [CW-1:0] par;   // parent of i
    logic [CW:0]   lch;   // left child of i
    logic [CW:0]   rch;
    smp_t          rdh;
    logic          full;
    assign par  = (i_reg - 1'b1) >> 1;
    assign lch  = {i_reg, 1'b1};
    assign rch  = lch + 1'b1;
    assign rdh  = smp_t'(rd[h_reg]);
    assign full = (cnt_reg[0] == CW'(HEAP_DEPTH)) && (cnt_reg[1] == CW'(HEAP_DEPTH));
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        top_next   = top_reg;
        op_next    = op_reg;
        oh_next    = oh_reg;
        ov_next    = ov_reg;
        h_next     = h_reg;
        i_next     = i_reg;
        v_next     = v_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        ref_next   = ref_reg;
        done_next  = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            we[k]   = 1'b0;
            addr[k] = '0;
            wd[k]   = v_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = smp_t'(sample[SW-1:0]);
                    ref_next   = full;
                    state_next = full ? ST_FIN_RD : ST_TOPS;
                end
            end
            ST_TOPS:
            begin
                state_next = ST_TOPS_W;
            end
            ST_TOPS_W:
            begin
                top_next[0] = smp_t'(rd[0]);
                top_next[1] = smp_t'(rd[1]);
                state_next  = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                op_next[1] = OP_NONE;
                op_next[2] = OP_NONE;
                ov_next[0] = x_reg;
                if (cnt_reg[0] == cnt_reg[1])
                begin
                    op_next[0] = OP_PUSH;
                    oh_next[0] = !((cnt_reg[0] == '0) || (x_reg < top_reg[0]));
                end
                else if (cnt_reg[0] > cnt_reg[1])
                begin
                    if (x_reg < top_reg[0])
                    begin
                        op_next[0] = OP_PUSH; oh_next[0] = 1'b1; ov_next[0] = top_reg[0];
                        op_next[1] = OP_POP;  oh_next[1] = 1'b0;
                        op_next[2] = OP_PUSH; oh_next[2] = 1'b0; ov_next[2] = x_reg;
                    end
                    else
                    begin
                        op_next[0] = OP_PUSH; oh_next[0] = 1'b1;
                    end
                end
                else
                begin
                    if (x_reg <= top_reg[1])
                    begin
                        op_next[0] = OP_PUSH; oh_next[0] = 1'b0;
                    end
                    else
                    begin
                        op_next[0] = OP_PUSH; oh_next[0] = 1'b0; ov_next[0] = top_reg[1];
                        op_next[1] = OP_POP;  oh_next[1] = 1'b1;
                        op_next[2] = OP_PUSH; oh_next[2] = 1'b1; ov_next[2] = x_reg;
                    end
                end
                state_next = ST_FIN_RD;  // FIN_RD dispatches ops when queued
            end
            ST_UP_RD:
            begin
                // read parent of i (i > 0 guaranteed)
                addr[h_reg] = AW'(par);
                state_next  = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                if (ahead(h_reg, v_reg, rdh))
                begin
                    we[h_reg]   = 1'b1;
                    addr[h_reg] = AW'(i_reg);
                    wd[h_reg]   = rdh;
                    i_next      = par;
                    state_next  = (par == '0) ? ST_FIN_W : ST_UP_RD;
                end
                else
                begin
                    state_next = ST_FIN_W;
                end
            end
            ST_DN_RD:
            begin
                // left child exists here
                addr[h_reg] = AW'(lch);
                state_next  = ST_DN_W1;
            end
            ST_DN_W1:
            begin
                c_next = rdh;
                if (rch < {1'b0, n_reg})
                begin
                    addr[h_reg] = AW'(rch);
                    state_next  = ST_DN_CMP;
                end
                else
                begin
                    // only left child
                    if (ahead(h_reg, rdh, v_reg))
                    begin
                        we[h_reg]   = 1'b1;
                        addr[h_reg] = AW'(i_reg);
                        wd[h_reg]   = rdh;
                        i_next      = CW'(lch);
                    end
                    state_next = ST_FIN_W;
                end
            end
            ST_DN_CMP:
            begin
                // pick best of v, left (c_reg), right (rdh)
                if (ahead(h_reg, c_reg, v_reg) && !ahead(h_reg, rdh, c_reg))
                begin
                    we[h_reg]   = 1'b1;
                    addr[h_reg] = AW'(i_reg);
                    wd[h_reg]   = c_reg;
                    i_next      = CW'(lch);
                    state_next  = ({lch, 1'b1} < {2'b0, n_reg}) ? ST_DN_RD : ST_FIN_W;
                end
                else if (ahead(h_reg, rdh, v_reg))
                begin
                    we[h_reg]   = 1'b1;
                    addr[h_reg] = AW'(i_reg);
                    wd[h_reg]   = rdh;
                    i_next      = CW'(rch);
                    state_next  = ({rch, 1'b1} < {2'b0, n_reg}) ? ST_DN_RD : ST_FIN_W;
                end
                else
                begin
                    state_next = ST_FIN_W;
                end
            end
            ST_FIN_W:
            begin
                // place sifted value at its final slot
                we[h_reg]   = 1'b1;
                addr[h_reg] = AW'(i_reg);
                wd[h_reg]   = v_reg;
                state_next  = ST_FIN_RD;
            end
            ST_FIN_RD:
            begin
                // dispatch next queued op, else read tops for the result
                if (!ref_reg && op_reg[0] != OP_NONE)
                begin
                    h_next     = oh_reg[0];
                    op_next[0] = op_reg[1]; oh_next[0] = oh_reg[1]; ov_next[0] = ov_reg[1];
                    op_next[1] = op_reg[2]; oh_next[1] = oh_reg[2]; ov_next[1] = ov_reg[2];
                    op_next[2] = OP_NONE;
                    if (op_reg[0] == OP_PUSH)
                    begin
                        v_next   = ov_reg[0];
                        i_next   = cnt_reg[oh_reg[0]];
                        cnt_next[oh_reg[0]] = cnt_reg[oh_reg[0]] + 1'b1;
                        state_next = (cnt_reg[oh_reg[0]] == '0) ? ST_FIN_W : ST_UP_RD;
                    end
                    else
                    begin
                        // pop: last entry becomes the sifted value
                        addr[oh_reg[0]] = AW'(cnt_reg[oh_reg[0]] - 1'b1);
                        n_next   = cnt_reg[oh_reg[0]] - 1'b1;
                        cnt_next[oh_reg[0]] = cnt_reg[oh_reg[0]] - 1'b1;
                        i_next   = '0;
                        state_next = ST_DONE;   // load v from RAM next
                        c_next   = '0;
                    end
                end
                else if (state_reg == ST_FIN_RD && op_reg[0] == OP_NONE && !done)
                begin
                    state_next = ST_DONE;
                    i_next     = '1;   // mark: result phase
                end
            end
            ST_DONE:
            begin
                if (i_reg != '1)
                begin
                    // pop load stage
                    v_next     = rdh;
                    state_next = (n_reg > 1) ? ST_DN_RD : ST_FIN_W;
                    if (n_reg == '0)
                    begin
                        state_next = ST_FIN_RD;
                    end
                end
                else
                begin
                    addr[0]    = '0;
                    addr[1]    = '0;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // tops read in ST_IDLE->done cycle: RAMs addressed at 0 during ST_DONE
    smp_t lt, ut;
    logic [MED_W-1:0] m2;
    assign lt = (cnt_reg[0] != '0) ? smp_t'(rd[0]) : '0;
    assign ut = (cnt_reg[1] != '0) ? smp_t'(rd[1]) : '0;
    always_comb
    begin
        if (cnt_reg[0] == cnt_reg[1])
        begin
            m2 = MED_W'($signed(lt)) + MED_W'($signed(ut));
        end
        else if (cnt_reg[0] > cnt_reg[1])
        begin
            m2 = MED_W'($signed(lt)) << 1;
        end
        else
        begin
            m2 = MED_W'($signed(ut)) << 1;
        end
    end
    assign median_times_two = m2;
    assign sample_count     = CNT_OUT'(cnt_reg[0]) + CNT_OUT'(cnt_reg[1]);
    assign refused          = ref_reg;

    `RMH_ASSERT_ALWAYS(a_bal, clk, rst_n, (cnt_reg[0] <= cnt_reg[1] + 1'b1) || busy, "heaps out of balance")
    `RMH_ASSERT_ALWAYS(a_done_idle, clk, rst_n, !done || !busy, "busy during done")
    `RMH_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
endmodule

FILE: verif/running_median_two_heaps_unit_tb.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit_tb
// Drives signed sample words into the running median unit and checks every
// result against a two-heap model kept inside the testbench. The stimulus
// starts with a short directed part covering extremes and ties. Random words
// follow, enough to fill both heaps and then hit the refusal path.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit_tb
    import rmh_pkg::*;
;
    localparam int DEPTH       = HEAP_DEPTH_DEF;
    localparam int RAND_WORDS  = 1830;
    localparam int CYCLE_LIMIT = 2000000;

    // one expected result word
    typedef struct {
        logic signed [MED_W-1:0] med2;
        logic [CNT_OUT-1:0]      count;
        logic                    drop;
    } median_word_t;

    // Two-heap median model plus the queue of expected words.
    class median_scoreboard;
        longint          low_half[DEPTH];   // max-heap
        longint          high_half[DEPTH];  // min-heap
        int              n_low;
        int              n_high;
        median_word_t    pending[$];
        int              fail_count;

        function new();
            n_low      = 0;
            n_high     = 0;
            fail_count = 0;
        endfunction

        function bit first(bit is_max, longint a, longint b);
            return is_max ? (a > b) : (a < b);
        endfunction

        function void heap_insert(bit is_max, longint v);
            int     i;
            int     p;
            longint t;
            if (is_max)
            begin
                i = n_low;
                low_half[i] = v;
                n_low++;
                while (i > 0)
                begin
                    p = (i - 1) / 2;
                    if (!first(1, low_half[i], low_half[p]))
                        break;
                    t = low_half[i]; low_half[i] = low_half[p]; low_half[p] = t;
                    i = p;
                end
            end
            else
            begin
                i = n_high;
                high_half[i] = v;
                n_high++;
                while (i > 0)
                begin
                    p = (i - 1) / 2;
                    if (!first(0, high_half[i], high_half[p]))
                        break;
                    t = high_half[i]; high_half[i] = high_half[p]; high_half[p] = t;
                    i = p;
                end
            end
        endfunction

        // removes the top; order inside the heap matches the block's sift-down
        function void heap_remove(bit is_max);
            int     n;
            int     i;
            int     l;
            int     r;
            int     best;
            longint t;
            i = 0;
            if (is_max)
            begin
                n = n_low - 1;
                n_low = n;
                low_half[0] = low_half[n];
                forever
                begin
                    l = 2 * i + 1; r = l + 1; best = i;
                    if (l < n && first(1, low_half[l], low_half[best])) best = l;
                    if (r < n && first(1, low_half[r], low_half[best])) best = r;
                    if (best == i) break;
                    t = low_half[i]; low_half[i] = low_half[best]; low_half[best] = t;
                    i = best;
                end
            end
            else
            begin
                n = n_high - 1;
                n_high = n;
                high_half[0] = high_half[n];
                forever
                begin
                    l = 2 * i + 1; r = l + 1; best = i;
                    if (l < n && first(0, high_half[l], high_half[best])) best = l;
                    if (r < n && first(0, high_half[r], high_half[best])) best = r;
                    if (best == i) break;
                    t = high_half[i]; high_half[i] = high_half[best]; high_half[best] = t;
                    i = best;
                end
            end
        endfunction

        // accepted input word: update the model, queue the expected result
        function void note_sample(logic signed [IN_W-1:0] s);
            longint       x;
            longint       lt;
            longint       ut;
            longint       m2;
            median_word_t w;
            x = longint'(s);
            w.drop = 1'b0;
            lt = n_low ? low_half[0] : 0;
            ut = n_high ? high_half[0] : 0;
            if (n_low >= DEPTH && n_high >= DEPTH)
            begin
                w.drop = 1'b1;
            end
            else if (n_low == n_high)
            begin
                if (n_low == 0 || x < lt) heap_insert(1, x);
                else heap_insert(0, x);
            end
            else if (n_low > n_high)
            begin
                if (x < lt)
                begin
                    heap_insert(0, lt);
                    heap_remove(1);
                    heap_insert(1, x);
                end
                else heap_insert(0, x);
            end
            else
            begin
                if (x <= ut) heap_insert(1, x);
                else
                begin
                    heap_insert(1, ut);
                    heap_remove(0);
                    heap_insert(0, x);
                end
            end
            lt = n_low ? low_half[0] : 0;
            ut = n_high ? high_half[0] : 0;
            if (n_low == n_high) m2 = lt + ut;
            else if (n_low > n_high) m2 = 2 * lt;
            else m2 = 2 * ut;
            w.med2  = m2[MED_W-1:0];
            w.count = CNT_OUT'(n_low + n_high);
            pending.push_back(w);
        endfunction

        function void check_result(logic signed [MED_W-1:0] med2,
                                   logic [CNT_OUT-1:0] count, logic drop);
            median_word_t w;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
                return;
            end
            w = pending.pop_front();
            if (med2 !== w.med2)
            begin
                $error("median_times_two: expected %0d, actual %0d", w.med2, med2);
                fail_count++;
            end
            if (count !== w.count)
            begin
                $error("sample_count: expected %0d, actual %0d", w.count, count);
                fail_count++;
            end
            if (drop !== w.drop)
            begin
                $error("refused: expected %0b, actual %0b", w.drop, drop);
                fail_count++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [IN_W-1:0]  sample;
    logic                    done;
    logic signed [MED_W-1:0] median_times_two;
    logic [CNT_OUT-1:0]      sample_count;
    logic                    refused;

    median_scoreboard sb;
    int               cycles;

    running_median_two_heaps_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .sample           (sample),
        .done             (done),
        .median_times_two (median_times_two),
        .sample_count     (sample_count),
        .refused          (refused)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side: done is a one-cycle strobe, so check at every edge it is up
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(median_times_two, sample_count, refused);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("running_median_two_heaps_unit_tb failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    // present one word at the falling edge and hold it until accepted
    task send_word(input logic signed [IN_W-1:0] s);
        int gap;
        sample = s;
        start  = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_sample(s);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // random word: wide values, a narrow band for ties, and the extremes
    function logic signed [IN_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom;
        if (r < 80) return $signed($urandom_range(0, 16)) - 8;
        if (r < 88) return 32'sh7fffffff - $urandom_range(0, 3);
        if (r < 96) return 32'sh80000000 + $urandom_range(0, 3);
        return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
    endfunction

    initial
    begin
        sb     = new();
        cycles = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        sample = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first word into an empty pair, both extremes, ties on tops
        send_word(32'sh7fffffff);
        send_word(32'sh7fffffff);           // lower larger, equal to lower top
        send_word(32'sh80000000);
        send_word(32'sh80000000);
        send_word(32'sh7fffffff);
        send_word(32'sh7fffffff);           // upper larger, sample near top
        send_word(0);
        send_word(0);
        send_word(-1);
        send_word(1);
        send_word(32'sh55555555);
        send_word(32'shaaaaaaaa);
        send_word(0);
        send_word(0);
        send_word(-1);
        send_word(-1);
        send_word(32'sh7ffffffe);
        send_word(32'sh80000001);
        send_word(5);
        send_word(5);

        // random: fills both heaps, then keeps going through refusals
        for (int k = 0; k < RAND_WORDS; k++)
            send_word(pick_sample());

        start = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sb.fail_count == 0)
            $display("running_median_two_heaps_unit_tb passed");
        else
            $display("running_median_two_heaps_unit_tb failed");
        $finish;
    end
endmodule
